/* sv/cau_pkg.sv */
// Package: shared types, operation codes and field widths for the 8-bit ALU.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int unsigned ModeW    = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FlagW    = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned WideW    = 16;

  // Flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD   = 5'd0,
    MODE_ADC   = 5'd1,
    MODE_SUB   = 5'd2,
    MODE_SBC   = 5'd3,
    MODE_AND   = 5'd4,
    MODE_XOR   = 5'd5,
    MODE_OR    = 5'd6,
    MODE_CP    = 5'd7,
    MODE_RLC   = 5'd8,
    MODE_RRC   = 5'd9,
    MODE_RL    = 5'd10,
    MODE_RR    = 5'd11,
    MODE_SLA   = 5'd12,
    MODE_SRA   = 5'd13,
    MODE_SWAP  = 5'd14,
    MODE_SRL   = 5'd15,
    MODE_BIT   = 5'd16,
    MODE_RES   = 5'd17,
    MODE_SET   = 5'd18,
    MODE_SPADD = 5'd19
  } mode_e;

  // One operation as held in the input register
  typedef struct packed {
    logic [WideW-1:0] stack_value;
    logic [IdxW-1:0]  bit_index;
    logic [FlagW-1:0] flags_in;
    logic [ByteW-1:0] operand;
    logic [ByteW-1:0] acc;
    logic [ModeW-1:0] mode;
  } op_t;

  // One result as held in the output register
  typedef struct packed {
    logic             write_result;
    logic [FlagW-1:0] flags_out;
    logic [WideW-1:0] result;
  } res_t;

  localparam int unsigned OpW  = $bits(op_t);
  localparam int unsigned ResW = $bits(res_t);

endpackage

/* sv/cau_stage.sv */
// Module: one valid/ready register slice holding a single word.
`timescale 1ns / 1ps

module cau_stage
  import cau_pkg::*;
#(
  parameter int unsigned Width = OpW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // Load whenever the slot is empty or being drained this cycle.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* sv/cau_alu.sv */
// Module: combinational ALU datapath, value, flags and write-enable per operation.
`timescale 1ns / 1ps

module cau_alu
  import cau_pkg::*;
(
  input  op_t  op_i,
  output res_t res_o
);

  logic [ByteW-1:0] a, b;
  logic [FlagW-1:0] fin;
  logic             cin;
  logic             c_add, c_sub;
  logic [ByteW:0]   sum9, diff9;
  logic [4:0]       hsum, hdiff;
  logic [ByteW:0]   sp_lo9;
  logic [4:0]       sp_h5;
  logic [WideW-1:0] sp_sum;
  logic [ByteW-1:0] v;
  logic [ByteW-1:0] bit_mask;

  always_comb begin
    a     = op_i.acc;
    b     = op_i.operand;
    fin   = op_i.flags_in;
    cin   = fin[FlagC];
    c_add = (mode_e'(op_i.mode) == MODE_ADC) ? cin : 1'b0;
    c_sub = (mode_e'(op_i.mode) == MODE_SBC) ? cin : 1'b0;

    sum9  = {1'b0, a} + {1'b0, b} + {{ByteW{1'b0}}, c_add};
    hsum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_add};
    diff9 = {1'b0, a} - {1'b0, b} - {{ByteW{1'b0}}, c_sub};
    hdiff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_sub};

    sp_lo9 = {1'b0, op_i.stack_value[ByteW-1:0]} + {1'b0, b};
    sp_h5  = {1'b0, op_i.stack_value[3:0]} + {1'b0, b[3:0]};
    sp_sum = op_i.stack_value + {{(WideW-ByteW){b[ByteW-1]}}, b};

    bit_mask = ByteW'(1) << op_i.bit_index;

    v                  = '0;
    res_o.result       = '0;
    res_o.flags_out    = fin;
    res_o.write_result = 1'b1;

    unique case (mode_e'(op_i.mode))
      MODE_ADD, MODE_ADC: begin
        v = sum9[ByteW-1:0];
        res_o.flags_out = {(v == '0), 1'b0, hsum[4], sum9[ByteW]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        v = diff9[ByteW-1:0];
        res_o.flags_out = {(v == '0), 1'b1, hdiff[4], diff9[ByteW]};
        if (mode_e'(op_i.mode) == MODE_CP) begin
          res_o.write_result = 1'b0;
        end
      end
      MODE_AND: begin
        v = a & b;
        res_o.flags_out = {(v == '0), 1'b0, 1'b1, 1'b0};
      end
      MODE_XOR: begin
        v = a ^ b;
        res_o.flags_out = {(v == '0), 3'b000};
      end
      MODE_OR: begin
        v = a | b;
        res_o.flags_out = {(v == '0), 3'b000};
      end
      MODE_RLC: begin
        v = {b[6:0], b[7]};
        res_o.flags_out = {(v == '0), 2'b00, b[7]};
      end
      MODE_RRC: begin
        v = {b[0], b[7:1]};
        res_o.flags_out = {(v == '0), 2'b00, b[0]};
      end
      MODE_RL: begin
        v = {b[6:0], cin};
        res_o.flags_out = {(v == '0), 2'b00, b[7]};
      end
      MODE_RR: begin
        v = {cin, b[7:1]};
        res_o.flags_out = {(v == '0), 2'b00, b[0]};
      end
      MODE_SLA: begin
        v = {b[6:0], 1'b0};
        res_o.flags_out = {(v == '0), 2'b00, b[7]};
      end
      MODE_SRA: begin
        v = {b[7], b[7:1]};
        res_o.flags_out = {(v == '0), 2'b00, b[0]};
      end
      MODE_SWAP: begin
        v = {b[3:0], b[7:4]};
        res_o.flags_out = {(v == '0), 3'b000};
      end
      MODE_SRL: begin
        v = {1'b0, b[7:1]};
        res_o.flags_out = {(v == '0), 2'b00, b[0]};
      end
      MODE_BIT: begin
        res_o.write_result = 1'b0;
        res_o.flags_out    = {((b & bit_mask) == '0), 1'b0, 1'b1, cin};
      end
      MODE_RES: begin
        v = b & ~bit_mask;
      end
      MODE_SET: begin
        v = b | bit_mask;
      end
      MODE_SPADD: begin
        res_o.flags_out = {2'b00, sp_h5[4], sp_lo9[ByteW]};
      end
      default: begin
        // undefined codes: no-op, flags pass through
        res_o.write_result = 1'b0;
      end
    endcase

    if (mode_e'(op_i.mode) == MODE_SPADD) begin
      res_o.result = sp_sum;
    end else begin
      res_o.result = {{(WideW-ByteW){1'b0}}, v};
    end
  end

endmodule

/* sv/cpu_alu8_with_flags_unit.sv */
// Top level: streaming 8-bit ALU with Z/N/H/C flags, input and result registers.
// Path: input register, then the one-pass ALU datapath, then the result register.
// Throughput: one word per cycle unless m_axis_tready stalls the result register.
// A finished result waits in the result register while the next word is taken.
// Reset (rst_ni low, async): both register slices empty, no result pending.
// Payload registers are not reset.
`timescale 1ns / 1ps

module cpu_alu8_with_flags_unit
  import cau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] acc, [15:8] operand, [19:16] flags_in, [22:20] bit_index,
  // [38:23] stack_value, [39] zero pad
  input  logic [39:0] s_axis_tdata,
  // [4:0] mode
  input  logic [4:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] result, [19:16] flags_out, [23:20] zero pad
  output logic [23:0] m_axis_tdata,
  // [0] write_result
  output logic        m_axis_tuser
);

  op_t  op_in, op_q;
  res_t res_d, res_q;

  logic [OpW-1:0]  op_in_bits, op_q_bits;
  logic [ResW-1:0] res_d_bits, res_q_bits;
  logic            op_valid, op_ready;

  // unpack bus into the operation struct
  always_comb begin
    op_in.mode        = s_axis_tuser;
    op_in.acc         = s_axis_tdata[7:0];
    op_in.operand     = s_axis_tdata[15:8];
    op_in.flags_in    = s_axis_tdata[19:16];
    op_in.bit_index   = s_axis_tdata[22:20];
    op_in.stack_value = s_axis_tdata[38:23];
  end

  assign op_in_bits = op_in;
  assign op_q       = op_t'(op_q_bits);

  // input register
  cau_stage #(
    .Width (OpW)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (op_in_bits),
    .valid_o (op_valid),
    .ready_i (op_ready),
    .data_o  (op_q_bits)
  );

  // single-pass datapath
  cau_alu u_alu (
    .op_i  (op_q),
    .res_o (res_d)
  );

  assign res_d_bits = res_d;

  // result register; frees the input register whenever it can take the word
  cau_stage #(
    .Width (ResW)
  ) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (op_valid),
    .ready_o (op_ready),
    .data_i  (res_d_bits),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_q_bits)
  );

  assign res_q        = res_t'(res_q_bits);
  assign m_axis_tdata = {4'b0000, res_q.flags_out, res_q.result};
  assign m_axis_tuser = res_q.write_result;

endmodule

/* dv/tb_cpu_alu8_with_flags_unit.sv */
// Testbench for cpu_alu8_with_flags_unit: directed table plus random words, checked by a predictor.
`timescale 1ns / 1ps

module tb_cpu_alu8_with_flags_unit;
  import cau_pkg::*;

  // Mode codes past MODE_SPADD are no-ops in the block
  localparam logic [ModeW-1:0] MODE_NOP_FIRST = 5'd20;
  localparam logic [ModeW-1:0] MODE_NOP_LAST  = 5'd31;

  localparam int RAND_WORDS   = 450;
  localparam int HOLD_CYCLES  = 40;
  localparam int DIR_ROWS     = 26;

  typedef struct packed {
    logic [WideW-1:0] value;
    logic [FlagW-1:0] flags;
    logic             wr;
  } alu_out_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] operand;
    logic [FlagW-1:0] flags_in;
    logic [IdxW-1:0]  bit_index;
    logic [WideW-1:0] stack_value;
    logic             typed;      // expectation below is used instead of the predictor
    logic [WideW-1:0] exp_value;
    logic [FlagW-1:0] exp_flags;  // Z N H C
    logic             exp_wr;
  } dir_row_t;

  // mode, acc, operand, flags, idx, sp, typed, value, flags, wr
  dir_row_t dir_table [DIR_ROWS] = '{
    '{MODE_ADD,   8'h00, 8'h00, 4'h0, 3'd0, 16'h0000, 1'b1, 16'h0000, 4'b1000, 1'b1},
    '{MODE_ADD,   8'hFF, 8'h01, 4'h0, 3'd0, 16'h0000, 1'b1, 16'h0000, 4'b1011, 1'b1},
    '{MODE_ADC,   8'h0F, 8'h00, 4'h1, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_SUB,   8'h00, 8'h01, 4'h0, 3'd0, 16'h0000, 1'b1, 16'h00FF, 4'b0111, 1'b1},
    '{MODE_SBC,   8'h10, 8'h0F, 4'h1, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_AND,   8'hF0, 8'h0F, 4'h0, 3'd0, 16'h0000, 1'b1, 16'h0000, 4'b1010, 1'b1},
    '{MODE_XOR,   8'hFF, 8'hFF, 4'h0, 3'd0, 16'h0000, 1'b1, 16'h0000, 4'b1000, 1'b1},
    '{MODE_OR,    8'h00, 8'h00, 4'hF, 3'd0, 16'h0000, 1'b1, 16'h0000, 4'b1000, 1'b1},
    '{MODE_CP,    8'h42, 8'h42, 4'h0, 3'd0, 16'h0000, 1'b1, 16'h0000, 4'b1100, 1'b0},
    '{MODE_RLC,   8'h00, 8'h80, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_RRC,   8'h00, 8'h01, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_RL,    8'h00, 8'h80, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_RR,    8'h00, 8'h01, 4'h1, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_SLA,   8'h00, 8'h80, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_SRA,   8'h00, 8'h81, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_SWAP,  8'h00, 8'hF0, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_SRL,   8'h00, 8'h01, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_BIT,   8'h00, 8'h00, 4'h1, 3'd7, 16'h0000, 1'b1, 16'h0000, 4'b1011, 1'b0},
    '{MODE_BIT,   8'h00, 8'hFF, 4'h0, 3'd0, 16'h0000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_RES,   8'h00, 8'hFF, 4'hF, 3'd0, 16'h0000, 1'b1, 16'h00FE, 4'b1111, 1'b1},
    '{MODE_SET,   8'h00, 8'h00, 4'h5, 3'd7, 16'h0000, 1'b1, 16'h0080, 4'b0101, 1'b1},
    '{MODE_SPADD, 8'h00, 8'h01, 4'hF, 3'd0, 16'hFFFF, 1'b1, 16'h0000, 4'b0011, 1'b1},
    '{MODE_SPADD, 8'h00, 8'h80, 4'hF, 3'd0, 16'h0000, 1'b1, 16'hFF80, 4'b0000, 1'b1},
    '{MODE_SPADD, 8'h00, 8'hFF, 4'h0, 3'd0, 16'h8000, 1'b0, 16'h0000, 4'b0000, 1'b0},
    '{MODE_NOP_LAST,  8'hFF, 8'hFF, 4'hA, 3'd7, 16'hFFFF, 1'b1, 16'h0000, 4'b1010, 1'b0},
    '{MODE_NOP_FIRST, 8'h12, 8'h34, 4'h5, 3'd3, 16'h5678, 1'b0, 16'h0000, 4'b0000, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [4:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  alu_out_t pending_alu_results [$];
  int       mismatch_count = 0;
  bit       steady_flow = 1'b0;     // both sides run without idling
  bit       hold_request = 1'b0;    // asks the receiver for a long hold-off

  cpu_alu8_with_flags_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Expected value, flags and write-enable for one operation
  function automatic alu_out_t alu_compute(op_t op);
    alu_out_t   o;
    logic [7:0] b;
    logic [7:0] r8;
    logic [8:0] wide9;
    logic [4:0] nib;
    logic       cin;
    logic       c;
    b   = op.operand;
    cin = op.flags_in[FlagC];
    r8  = 8'h00;
    o.flags = op.flags_in;
    o.wr    = 1'b1;
    case (op.mode)
      MODE_ADD, MODE_ADC: begin
        c     = (op.mode == MODE_ADC) ? cin : 1'b0;
        wide9 = {1'b0, op.acc} + {1'b0, b} + {8'h00, c};
        nib   = {1'b0, op.acc[3:0]} + {1'b0, b[3:0]} + {4'h0, c};
        r8    = wide9[7:0];
        o.flags = {r8 == 8'h00, 1'b0, nib[4], wide9[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        // borrow shows as the bit above the operand width
        c     = (op.mode == MODE_SBC) ? cin : 1'b0;
        wide9 = {1'b0, op.acc} - {1'b0, b} - {8'h00, c};
        nib   = {1'b0, op.acc[3:0]} - {1'b0, b[3:0]} - {4'h0, c};
        r8    = wide9[7:0];
        o.flags = {r8 == 8'h00, 1'b1, nib[4], wide9[8]};
        o.wr    = (op.mode != MODE_CP);
      end
      MODE_AND: begin
        r8 = op.acc & b;
        o.flags = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      MODE_XOR: begin
        r8 = op.acc ^ b;
        o.flags = {r8 == 8'h00, 3'b000};
      end
      MODE_OR: begin
        r8 = op.acc | b;
        o.flags = {r8 == 8'h00, 3'b000};
      end
      MODE_RLC: begin
        r8 = {b[6:0], b[7]};
        o.flags = {r8 == 8'h00, 2'b00, b[7]};
      end
      MODE_RRC: begin
        r8 = {b[0], b[7:1]};
        o.flags = {r8 == 8'h00, 2'b00, b[0]};
      end
      MODE_RL: begin
        r8 = {b[6:0], cin};
        o.flags = {r8 == 8'h00, 2'b00, b[7]};
      end
      MODE_RR: begin
        r8 = {cin, b[7:1]};
        o.flags = {r8 == 8'h00, 2'b00, b[0]};
      end
      MODE_SLA: begin
        r8 = {b[6:0], 1'b0};
        o.flags = {r8 == 8'h00, 2'b00, b[7]};
      end
      MODE_SRA: begin
        r8 = {b[7], b[7:1]};
        o.flags = {r8 == 8'h00, 2'b00, b[0]};
      end
      MODE_SWAP: begin
        r8 = {b[3:0], b[7:4]};
        o.flags = {r8 == 8'h00, 3'b000};
      end
      MODE_SRL: begin
        r8 = {1'b0, b[7:1]};
        o.flags = {r8 == 8'h00, 2'b00, b[0]};
      end
      MODE_BIT: begin
        o.wr    = 1'b0;
        o.flags = {~b[op.bit_index], 1'b0, 1'b1, cin};
      end
      MODE_RES: r8 = b & ~(8'h01 << op.bit_index);
      MODE_SET: r8 = b | (8'h01 << op.bit_index);
      MODE_SPADD: begin
        // flags come from the unsigned low-byte add, value from the signed add
        wide9 = {1'b0, op.stack_value[7:0]} + {1'b0, b};
        nib   = {1'b0, op.stack_value[3:0]} + {1'b0, b[3:0]};
        o.flags = {2'b00, nib[4], wide9[8]};
      end
      default: o.wr = 1'b0;
    endcase
    if (op.mode == MODE_SPADD) o.value = op.stack_value + {{8{b[7]}}, b};
    else o.value = {8'h00, r8};
    return o;
  endfunction

  // Bytes lean toward the corners that flip carries and zero flags
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return ($urandom_range(1) != 0) ? 8'h80 : 8'h7F;
      3: return ($urandom_range(1) != 0) ? 8'h0F : 8'h10;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic op_t random_op();
    op_t op;
    if ($urandom_range(11) == 0) op.mode = 5'($urandom_range(MODE_NOP_LAST, MODE_NOP_FIRST));
    else op.mode = 5'($urandom_range(MODE_SPADD, MODE_ADD));
    op.acc       = pick_byte();
    op.operand   = pick_byte();
    op.flags_in  = 4'($urandom);
    op.bit_index = 3'($urandom);
    case ($urandom_range(9))
      0: op.stack_value = 16'h0000;
      1: op.stack_value = 16'hFFFF;
      2: op.stack_value = ($urandom_range(1) != 0) ? 16'h00FF : 16'hFF00;
      default: op.stack_value = 16'($urandom);
    endcase
    return op;
  endfunction

  task automatic log_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one word, with random idle cycles ahead of it, and log its expectation
  task automatic send_word(op_t op, alu_out_t want);
    while (!steady_flow && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, op.stack_value, op.bit_index, op.flags_in, op.operand, op.acc};
    s_axis_tuser  <= op.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_alu_results.push_back(want);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          m_axis_tready <= 1'b0;
          @(negedge clk_i);
        end
      end
      if (steady_flow) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(99) >= 33);
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin
    alu_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_alu_results.size() == 0) begin
        log_mismatch("result word with nothing pending", m_axis_tdata[15:0], 16'h0000);
      end else begin
        want = pending_alu_results.pop_front();
        if (m_axis_tdata[15:0] !== want.value)
          log_mismatch("result", m_axis_tdata[15:0], want.value);
        if (m_axis_tdata[19:16] !== want.flags)
          log_mismatch("flags_out", 16'(m_axis_tdata[19:16]), 16'(want.flags));
        if (m_axis_tuser !== want.wr)
          log_mismatch("write_result", 16'(m_axis_tuser), 16'(want.wr));
      end
    end
  end

  initial begin : stimulus
    op_t      op;
    alu_out_t want;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      op.mode        = dir_table[r].mode;
      op.acc         = dir_table[r].acc;
      op.operand     = dir_table[r].operand;
      op.flags_in    = dir_table[r].flags_in;
      op.bit_index   = dir_table[r].bit_index;
      op.stack_value = dir_table[r].stack_value;
      if (dir_table[r].typed)
        want = '{dir_table[r].exp_value, dir_table[r].exp_flags, dir_table[r].exp_wr};
      else
        want = alu_compute(op);
      send_word(op, want);
    end

    for (int k = 0; k < RAND_WORDS; k++) begin
      steady_flow = (k >= 150 && k < 250);
      // receiver goes quiet while words keep coming: both slices fill up
      if (k == 80) hold_request = 1'b1;
      // sender waits out the pipeline once
      if (k == 320) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        while (pending_alu_results.size() != 0) @(posedge clk_i);
      end
      op = random_op();
      send_word(op, alu_compute(op));
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_alu_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_alu_results.size() == 0) begin
      $display("PASS cpu_alu8_with_flags_unit");
    end else begin
      $display("FAIL cpu_alu8_with_flags_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #1ms;
    $display("FAIL cpu_alu8_with_flags_unit");
    $finish;
  end

endmodule

/* files.f */
sv/cau_pkg.sv
sv/cau_stage.sv
sv/cau_alu.sv
sv/cpu_alu8_with_flags_unit.sv
dv/tb_cpu_alu8_with_flags_unit.sv
